/* rtl/srit_pkg.sv */
package srit_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ID_BITS  = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned POS_W    = 7;

  // Request modes; codes 5 to 7 are no-ops.
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic    latch;
    logic    scan_start;
    logic    scan_step;
    logic    ins_wr;
    logic    last_rd;
    logic    move_wr;
    logic    idx_rd;
    logic    clr;
    logic    rsp_load;
    status_e status;
    logic    use_pos;
    logic    use_entry;
  } srit_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              hit;
    logic              scan_done;
    logic              idx_ok;
    logic              rsp_free;
  } srit_sts_t;

endpackage

/* rtl/srit_req_if.sv */
interface srit_req_if;
  import srit_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ID_BITS-1:0]  obj_id;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, output mode, output obj_id, output index, input ready);
  modport sink   (input valid, input mode, input obj_id, input index, output ready);
endinterface

/* rtl/srit_rsp_if.sv */
interface srit_rsp_if;
  import srit_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   position;
  logic [ID_BITS-1:0] entry_id;
  logic [CNT_W-1:0]   occupancy;
  logic               empty_res;

  modport source (output valid, output status, output position, output entry_id,
                  output occupancy, output empty_res, input ready);
  modport sink   (input valid, input status, input position, input entry_id,
                  input occupancy, input empty_res, output ready);
endinterface

/* rtl/srit_ctrl.sv */
module srit_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  srit_pkg::srit_sts_t sts_i,
  output srit_pkg::srit_cmd_t cmd_o
);
  import srit_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_LAST_RD  = 7'b0001000,
    S_MOVE_WR  = 7'b0010000,
    S_RD_WAIT  = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    use_pos_q, use_pos_d;
  logic    use_entry_q, use_entry_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    use_pos_d   = use_pos_q;
    use_entry_d = use_entry_q;
    cmd_o           = '0;
    cmd_o.status    = status_q;
    cmd_o.use_pos   = use_pos_q;
    cmd_o.use_entry = use_entry_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_d    = ST_OK;
        use_pos_d   = 1'b0;
        use_entry_d = 1'b0;
        state_d     = S_RESP;
        unique case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.full) status_d = ST_FULL;
            else cmd_o.ins_wr = 1'b1;
          end
          MODE_REMOVE, MODE_FIND: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
          MODE_CLEAR: cmd_o.clr = 1'b1;
          MODE_READ: begin
            if (sts_i.idx_ok) begin
              cmd_o.idx_rd = 1'b1;
              use_entry_d  = 1'b1;
              state_d      = S_RD_WAIT;
            end else begin
              status_d = ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          use_pos_d = 1'b1;
          state_d   = (sts_i.mode == MODE_REMOVE) ? S_LAST_RD : S_RESP;
        end else if (sts_i.scan_done) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end
      end
      S_LAST_RD: begin
        cmd_o.last_rd = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.move_wr = 1'b1;
        state_d       = S_RESP;
      end
      S_RD_WAIT: state_d = S_RESP;
      S_RESP: begin
        if (sts_i.rsp_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      use_pos_q   <= 1'b0;
      use_entry_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      use_pos_q   <= use_pos_d;
      use_entry_q <= use_entry_d;
    end
  end

endmodule

/* rtl/srit_dp.sv */
module srit_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [srit_pkg::MODE_W-1:0]  mode_i,
  input  logic [srit_pkg::ID_BITS-1:0] obj_id_i,
  input  logic [srit_pkg::INDEX_W-1:0] index_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [1:0]                   status_o,
  output logic [srit_pkg::POS_W-1:0]   position_o,
  output logic [srit_pkg::ID_BITS-1:0] entry_id_o,
  output logic [srit_pkg::CNT_W-1:0]   occupancy_o,
  output logic                         empty_res_o,
  input  srit_pkg::srit_cmd_t          cmd_i,
  output srit_pkg::srit_sts_t          sts_o
);
  import srit_pkg::*;

  // Request holding registers.
  logic [MODE_W-1:0]  mode_q;
  logic [ID_BITS-1:0] id_q;
  logic [INDEX_W-1:0] index_q;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_addr_q, scan_addr_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_addr_q;
  logic [IDX_W-1:0]   pos_q;

  logic [ID_BITS-1:0] mem [CAPACITY];
  logic [ID_BITS-1:0] rd_data_q;

  logic               hit, issue, rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr, last_addr;
  logic [ID_BITS-1:0] wr_data;
  logic [CNT_W-1:0]   count_m1;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [ID_BITS-1:0] out_entry_q;
  logic [CNT_W-1:0]   out_occ_q;
  logic               out_empty_q;

  assign hit       = pend_q && (rd_data_q == id_q);
  assign issue     = cmd_i.scan_step && !hit && (scan_addr_q < count_q);
  assign count_m1  = count_q - CNT_W'(1);
  assign last_addr = count_m1[IDX_W-1:0];

  assign sts_o.mode      = mode_q;
  assign sts_o.full      = (count_q == CNT_W'(CAPACITY));
  assign sts_o.hit       = hit;
  assign sts_o.scan_done = !pend_q && (scan_addr_q >= count_q);
  assign sts_o.idx_ok    = (CNT_W'(index_q) < count_q);
  assign sts_o.rsp_free  = !out_valid_q || rsp_ready_i;

  always_comb begin
    rd_en   = issue || cmd_i.last_rd || cmd_i.idx_rd;
    rd_addr = scan_addr_q[IDX_W-1:0];
    if (cmd_i.last_rd) rd_addr = last_addr;
    else if (cmd_i.idx_rd) rd_addr = index_q[IDX_W-1:0];

    wr_en   = cmd_i.ins_wr || cmd_i.move_wr;
    wr_addr = cmd_i.move_wr ? pos_q : count_q[IDX_W-1:0];
    wr_data = cmd_i.move_wr ? rd_data_q : id_q;

    count_d = count_q;
    if (cmd_i.clr) count_d = '0;
    else if (cmd_i.ins_wr) count_d = count_q + CNT_W'(1);
    else if (cmd_i.move_wr) count_d = count_m1;

    scan_addr_d = scan_addr_q;
    pend_d      = pend_q;
    if (cmd_i.scan_start) begin
      scan_addr_d = '0;
      pend_d      = 1'b0;
    end else if (cmd_i.scan_step) begin
      pend_d = issue;
      if (issue) scan_addr_d = scan_addr_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q  <= mode_i;
      id_q    <= obj_id_i;
      index_q <= index_i;
    end
    if (issue) pend_addr_q <= scan_addr_q[IDX_W-1:0];
    if (cmd_i.scan_step && hit) pos_q <= pend_addr_q;
    if (cmd_i.rsp_load) begin
      out_status_q <= cmd_i.status;
      out_pos_q    <= cmd_i.use_pos ? POS_W'(pos_q) : '0;
      out_entry_q  <= cmd_i.use_entry ? rd_data_q : '0;
      out_occ_q    <= count_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_addr_q <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_addr_q <= scan_addr_d;
      pend_q      <= pend_d;
      if (cmd_i.rsp_load) out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;
  assign entry_id_o  = out_entry_q;
  assign occupancy_o = out_occ_q;
  assign empty_res_o = out_empty_q;

endmodule

/* rtl/swap_remove_id_table_unit.sv */
// Unordered table of object IDs with swap-on-remove and an occupancy count.
//
// Channels: req_i (sink) carries mode, obj_id and index; rsp_o (source)
// carries status, position, entry_id, occupancy and empty_res. Each request
// transfer produces exactly one response transfer, in order.
//
// Per request: insert, clear, no-op and an out-of-range read go from
// dispatch straight to the response; an in-range read waits for the
// registered RAM read; find scans the occupied slots; remove scans, then
// reads the last entry and writes it over the hit slot, which also
// decrements the count.
// Find and remove walk the entry RAM one slot per cycle through its single
// registered read port.
// One request at a time; req_i.ready is high only while idle.
//
// The response sits in an output register: a stalled receiver does not block
// the next request transfer, only the loading of its response.
// Reset empties the table (occupancy 0) and drops any pending response; the
// entry RAM itself is not cleared, since slots at or above the count are
// never read.
module swap_remove_id_table_unit (
  input logic      clk_i,
  input logic      rst_ni,
  srit_req_if.sink   req_i,
  srit_rsp_if.source rsp_o
);
  import srit_pkg::*;

  srit_cmd_t cmd;
  srit_sts_t sts;
  logic      req_ready;

  // Sequencer: one-hot state machine issuing datapath commands.
  srit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // Entry RAM, count, scan pointer and response register.
  srit_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (req_i.mode),
    .obj_id_i    (req_i.obj_id),
    .index_i     (req_i.index),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status),
    .position_o  (rsp_o.position),
    .entry_id_o  (rsp_o.entry_id),
    .occupancy_o (rsp_o.occupancy),
    .empty_res_o (rsp_o.empty_res),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // Count never exceeds capacity.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.occupancy <= CNT_W'(CAPACITY)))
    else $error("occupancy above capacity");

  // Empty flag tracks occupancy.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.empty_res == (rsp_o.occupancy == '0)))
    else $error("empty flag mismatch");

  // Full status only with a full table.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FULL)) |-> (rsp_o.occupancy == CNT_W'(CAPACITY)))
    else $error("full status with free slots");

  // A request transfer closes the input until its response is loaded.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request accepted while busy");
`endif

endmodule
